FILE: hdl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_SUM     = 2'd2,
        REQ_LARGEST = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTALLOC = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FMT0,
        S_FMT1,
        S_RD,
        S_HDR,
        S_MRG,
        S_EVAL,
        S_SPLIT,
        S_NXT
    } t_state;

    typedef enum logic [1:0] {
        RD_W,
        RD_NEXT_RD,
        RD_NEXT_MRG
    } t_rd_sel;

    typedef struct packed {
        logic    load_req;
        logic    load_fmt;
        logic    fmt_wr0;
        logic    fmt_wr1;
        logic    hdr;
        logic    merge;
        t_rd_sel rd_sel;
        logic    step;
        logic    acc;
        logic    alloc_wr;
        logic    split_wr;
        logic    free_wr;
        logic    finish;
        t_status fin_status;
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic size_zero;
        logic rd_zero;
        logic rd_pos;
        logic rd_neg;
        logic fits;
        logic split;
        logic addr_eq;
        logic addr_gt;
    } t_sts;

endpackage

FILE: hdl/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator.
// Walk: each header is read (S_RD, S_HDR); on an alloc or query a free block absorbs
// its free neighbors (S_MRG) and is evaluated (S_EVAL), other blocks are passed (S_NXT);
// a split writes the remainder (S_SPLIT); a zero-size alloc ends in S_RD; done follows.
// Throughput: one item at a time; busy drops in the cycle of the one-cycle result strobe.
// Reset and every pool size write format the header memory in S_FMT0, S_FMT1; no stall input.
`timescale 1ns / 1ps
module first_fit_block_allocator_unit #(
    parameter int POOL_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [12:0] i_req_size,
    input  logic [11:0] i_block_addr,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [11:0] o_payload_addr,
    output logic [12:0] o_byte_count
);
    import ffba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ffba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cfg_we (i_cfg_we),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ffba_dp #(.POOL_BYTES(POOL_BYTES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_block_addr   (i_block_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_payload_addr (o_payload_addr),
        .o_byte_count   (o_byte_count)
    );
endmodule

FILE: hdl/ffba_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ffba_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/ffba_ctrl.sv
// Controller state machine for the allocator walk.
`timescale 1ns / 1ps
module ffba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_cfg_we,
    input  ffba_pkg::t_sts i_sts,
    output ffba_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import ffba_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FMT0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_RD;
            end
            S_FMT0: n_state = S_FMT1;
            S_FMT1: n_state = S_IDLE;
            S_RD: begin
                if (i_sts.is_alloc && i_sts.size_zero) n_state = S_IDLE;
                else n_state = S_HDR;
            end
            S_HDR: begin
                if (i_sts.rd_zero) n_state = S_IDLE;
                else if (i_sts.is_free) begin
                    if (i_sts.addr_eq || i_sts.addr_gt) n_state = S_IDLE;
                    else n_state = S_NXT;
                end else if (i_sts.rd_pos) n_state = S_MRG;
                else n_state = S_NXT;
            end
            S_MRG: begin
                if (!i_sts.rd_pos) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.is_alloc && i_sts.fits) begin
                    n_state = i_sts.split ? S_SPLIT : S_IDLE;
                end else begin
                    n_state = S_NXT;
                end
            end
            S_SPLIT: n_state = S_IDLE;
            S_NXT:   n_state = S_RD;
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_state = S_FMT0;
    end

    always_comb begin
        cmd = '0;
        cmd.rd_sel = RD_W;
        cmd.fin_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                cmd.load_req = i_start && !i_cfg_we;
            end
            S_FMT0: cmd.fmt_wr0 = 1'b1;
            S_FMT1: cmd.fmt_wr1 = 1'b1;
            S_RD: begin
                if (i_sts.is_alloc && i_sts.size_zero) begin
                    cmd.finish = 1'b1;
                    cmd.fin_status = ST_NOSPACE;
                end
            end
            S_HDR: begin
                cmd.hdr = 1'b1;
                if (i_sts.rd_zero) begin
                    cmd.finish = 1'b1;
                    if (i_sts.is_alloc) cmd.fin_status = ST_NOSPACE;
                    else if (i_sts.is_free) cmd.fin_status = ST_NOTALLOC;
                end else if (i_sts.is_free) begin
                    if (i_sts.addr_eq) begin
                        cmd.finish = 1'b1;
                        if (i_sts.rd_neg) cmd.free_wr = 1'b1;
                        else cmd.fin_status = ST_NOTALLOC;
                    end else if (i_sts.addr_gt) begin
                        cmd.finish = 1'b1;
                        cmd.fin_status = ST_NOTALLOC;
                    end
                end else if (i_sts.rd_pos) begin
                    cmd.rd_sel = RD_NEXT_RD;
                end
            end
            S_MRG: begin
                if (i_sts.rd_pos) begin
                    cmd.merge = 1'b1;
                    cmd.rd_sel = RD_NEXT_MRG;
                end
            end
            S_EVAL: begin
                if (i_sts.is_alloc) begin
                    if (i_sts.fits) begin
                        cmd.alloc_wr = 1'b1;
                        cmd.finish = !i_sts.split;
                    end
                end else begin
                    cmd.acc = 1'b1;
                end
            end
            S_SPLIT: begin
                cmd.split_wr = 1'b1;
                cmd.finish = 1'b1;
            end
            S_NXT: cmd.step = 1'b1;
            default: cmd = cmd;
        endcase
        if (i_cfg_we) begin
            cmd = '0;
            cmd.rd_sel = RD_W;
            cmd.fin_status = ST_OK;
            cmd.load_fmt = 1'b1;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
endmodule

FILE: hdl/ffba_dp.sv
// Datapath: header memory, walk registers, format values and result registers.
`timescale 1ns / 1ps
module ffba_dp #(
    parameter int POOL_BYTES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ffba_pkg::t_cmd         i_cmd,
    input  logic [1:0]             i_req_type,
    input  logic [12:0]            i_req_size,
    input  logic [11:0]            i_block_addr,
    input  logic [12:0]            i_cfg_wdata,
    output ffba_pkg::t_sts         o_sts,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [11:0]            o_payload_addr,
    output logic [12:0]            o_byte_count
);
    import ffba_pkg::*;

    localparam int NWORDS = POOL_BYTES / 8;
    localparam int WA     = $clog2(NWORDS);
    localparam int HW     = $clog2(POOL_BYTES) + 2;
    localparam int CW     = (HW > 14) ? HW : 14;
    localparam int AW     = (WA + 4 > 13) ? WA + 4 : 13;
    localparam int RSTB   = (POOL_BYTES < 4096) ? POOL_BYTES : 4096;

    function automatic logic [WA-1:0] next_w(input logic [WA-1:0] w,
                                             input logic signed [HW-1:0] h);
        logic [HW-1:0] m;
        logic [WA:0]   s;
        m = h[HW-1] ? (~h + 1'b1) : h;
        s = {1'b0, w} + (WA+1)'(m[HW-2:3]) + (WA+1)'(1);
        return s[WA-1:0];
    endfunction

    t_req                r_type;
    logic [CW-1:0]       r_size;
    logic [11:0]         r_addr;
    logic [WA-1:0]       r_w;
    logic signed [HW-1:0] r_h;
    logic [HW-2:0]       r_sum;
    logic [HW-2:0]       r_best;
    logic signed [HW-1:0] r_fmt_h0;
    logic [WA-1:0]       r_fmt_endw;
    logic                r_done;
    logic [1:0]          r_status;
    logic [11:0]         r_paddr;
    logic [12:0]         r_count;

    logic signed [HW-1:0] rd_data;
    logic signed [HW-1:0] merged;
    logic [WA-1:0]       raddr;
    logic                we;
    logic [WA-1:0]       waddr;
    logic [HW-1:0]       wdata;
    logic [CW-1:0]       hmag;
    logic [AW-1:0]       pofs;
    logic [13:0]         rsize;
    logic [CW-1:0]       fv;
    logic [CW-1:0]       qsel;
    logic                split;

    ffba_ram #(.WIDTH(HW), .DEPTH(NWORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign merged = r_h + rd_data + HW'(8);
    assign hmag   = CW'(r_h[HW-2:0]);
    assign pofs   = AW'({r_w, 3'b000}) + AW'(8);
    assign rsize  = ({1'b0, i_req_size} + 14'd7) & ~14'd7;
    assign split  = {1'b0, hmag} > ({1'b0, r_size} + (CW+1)'(8));

    always_comb begin
        fv = CW'(i_cfg_wdata);
        if (fv < CW'(32)) fv = CW'(32);
        if (fv > CW'(POOL_BYTES)) fv = CW'(POOL_BYTES);
        fv = fv & ~CW'(7);
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_NEXT_RD:  raddr = next_w(r_w, rd_data);
            RD_NEXT_MRG: raddr = next_w(r_w, merged);
            default:     raddr = r_w;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = r_w;
        wdata = '0;
        if (i_cmd.fmt_wr0) begin
            waddr = '0;
            wdata = r_fmt_h0;
        end else if (i_cmd.fmt_wr1) begin
            waddr = r_fmt_endw;
        end else if (i_cmd.merge) begin
            wdata = merged;
        end else if (i_cmd.alloc_wr) begin
            wdata = split ? (~HW'(r_size) + 1'b1) : (~r_h + 1'b1);
        end else if (i_cmd.split_wr) begin
            waddr = WA'(r_w + WA'(r_size[WA+2:3]) + WA'(1));
            wdata = r_h - HW'(r_size) - HW'(8);
        end else if (i_cmd.free_wr) begin
            wdata = ~rd_data + 1'b1;
        end else begin
            we = 1'b0;
        end
    end

    always_comb begin
        qsel = (r_type == REQ_SUM) ? CW'(r_sum) : CW'(r_best);
        if (qsel > CW'(8191)) qsel = CW'(8191);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_h0   <= HW'(RSTB - 16);
            r_fmt_endw <= WA'(RSTB / 8 - 1);
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.load_fmt) begin
                r_fmt_h0   <= HW'(fv - CW'(16));
                r_fmt_endw <= WA'(fv[CW-1:3] - (CW-3)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type <= t_req'(i_req_type);
            r_size <= CW'(rsize);
            r_addr <= i_block_addr;
            r_w    <= '0;
            r_sum  <= '0;
            r_best <= '0;
        end
        if (i_cmd.hdr) r_h <= rd_data;
        if (i_cmd.merge) r_h <= merged;
        if (i_cmd.step) r_w <= next_w(r_w, r_h);
        if (i_cmd.acc) begin
            r_sum <= r_sum + r_h[HW-2:0];
            if (r_h[HW-2:0] > r_best) r_best <= r_h[HW-2:0];
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.fin_status;
            r_paddr  <= (r_type == REQ_ALLOC && i_cmd.fin_status == ST_OK) ?
                        pofs[11:0] : 12'd0;
            r_count  <= (r_type == REQ_SUM || r_type == REQ_LARGEST) ?
                        qsel[12:0] : 13'd0;
        end
    end

    assign o_sts.is_alloc  = (r_type == REQ_ALLOC);
    assign o_sts.is_free   = (r_type == REQ_FREE);
    assign o_sts.size_zero = (r_size == '0);
    assign o_sts.rd_zero   = (rd_data == '0);
    assign o_sts.rd_pos    = !rd_data[HW-1] && (rd_data != '0);
    assign o_sts.rd_neg    = rd_data[HW-1];
    assign o_sts.fits      = hmag >= r_size;
    assign o_sts.split     = split;
    assign o_sts.addr_eq   = pofs == AW'(r_addr);
    assign o_sts.addr_gt   = pofs > AW'(r_addr);

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_payload_addr = r_paddr;
    assign o_byte_count   = r_count;
endmodule

FILE: hdl/ffba_checker.sv
// Port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps
module ffba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_cfg_we,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [11:0] o_payload_addr,
    input logic [12:0] o_byte_count
);
    import ffba_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_NOSPACE ||
                    o_status == ST_NOTALLOC))
        else $error("undefined status code");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_payload_addr == 12'd0 &&
                                           o_byte_count == 13'd0))
        else $error("failed item carries nonzero payload");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !$past(i_cfg_we)) |-> !busy || start)
        else $error("result shown while still busy");
endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cfg_we       (i_cfg_we),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_payload_addr (o_payload_addr),
    .o_byte_count   (o_byte_count)
);

FILE: test/tb_first_fit_block_allocator_unit.sv
// Self-checking testbench for the first-fit block allocator: directed table, random requests.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator_unit;
    import ffba_pkg::*;

    localparam int POOL_MAX = 4096;
    localparam int NUM_WORDS = POOL_MAX / 8;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct {
        t_status     status;
        logic [11:0] payload_addr;
        logic [12:0] byte_count;
    } t_reply;

    typedef struct {
        t_req        req;
        int          size;
        int          addr;
        bit          typed;
        t_reply      reply;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [12:0] i_req_size;
    logic [11:0] i_block_addr;
    logic        i_cfg_we;
    logic [12:0] i_cfg_wdata;
    logic        o_done;
    logic [1:0]  o_status;
    logic [11:0] o_payload_addr;
    logic [12:0] o_byte_count;

    int     header_words[NUM_WORDS];
    int     pool_now_bytes;
    t_reply pending_replies[$];
    t_row   typed_rows[$];
    int     live_blocks[$];
    int     mismatches;
    int     items_sent;
    int     replies_seen;
    int     idle_pct;

    first_fit_block_allocator_unit #(.POOL_BYTES(POOL_MAX)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_req_size(i_req_size), .i_block_addr(i_block_addr),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_done(o_done),
        .o_status(o_status), .o_payload_addr(o_payload_addr), .o_byte_count(o_byte_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

    function automatic void format_pool(int value);
        int end_word;
        if (value < 32) value = 32;
        if (value > POOL_MAX) value = POOL_MAX;
        value = value & ~7;
        pool_now_bytes = value;
        end_word = value / 8 - 1;
        foreach (header_words[k]) header_words[k] = 0;
        header_words[0] = (end_word - 1) * 8;
    endfunction

    function automatic int following_word(int w, int h);
        return w + (h < 0 ? -h : h) / 8 + 1;
    endfunction

    function automatic int coalesce_at(int w);
        int h;
        int n;
        h = header_words[w];
        while (h > 0) begin
            n = following_word(w, h);
            if (n >= NUM_WORDS) break;
            if (header_words[n] <= 0) break;
            h = h + header_words[n] + 8;
            header_words[w] = h;
        end
        return h;
    endfunction

    function automatic t_reply serve_request(t_req req, int size, int addr);
        t_reply r;
        int w;
        int h;
        int total;
        int best;
        r.status = ST_OK;
        r.payload_addr = '0;
        r.byte_count = '0;
        w = 0;
        total = 0;
        best = 0;
        if (req == REQ_ALLOC) begin
            size = (size + 7) & ~7;
            r.status = ST_NOSPACE;
            if (size != 0) begin
                while (w < NUM_WORDS) begin
                    h = coalesce_at(w);
                    if (h == 0) break;
                    if (h > 0 && h >= size) begin
                        if (h > size + 8) begin
                            header_words[w] = -size;
                            header_words[w + size / 8 + 1] = h - size - 8;
                        end else begin
                            header_words[w] = -h;
                        end
                        r.status = ST_OK;
                        r.payload_addr = 12'(w * 8 + 8);
                        break;
                    end
                    w = following_word(w, h);
                end
            end
        end else if (req == REQ_FREE) begin
            r.status = ST_NOTALLOC;
            while (w < NUM_WORDS) begin
                h = header_words[w];
                if (h == 0) break;
                if (w * 8 + 8 == addr) begin
                    if (h < 0) begin
                        header_words[w] = -h;
                        r.status = ST_OK;
                    end
                    break;
                end
                if (w * 8 + 8 > addr) break;
                w = following_word(w, h);
            end
        end else begin
            while (w < NUM_WORDS) begin
                h = coalesce_at(w);
                if (h == 0) break;
                if (h > 0) begin
                    total += h;
                    if (h > best) best = h;
                end
                w = following_word(w, h);
            end
            if (req == REQ_SUM) best = total;
            r.byte_count = 13'(best > 8191 ? 8191 : best);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Each accepted item is predicted at the edge that accepts it.
    always @(posedge i_clk) begin
        t_reply r;
        t_reply got;
        t_row   row;
        int idx;
        if (i_rst_n) begin
            if (o_done) begin
                replies_seen++;
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    got = pending_replies.pop_front();
                    if (o_status !== got.status)
                        report_mismatch("status", o_status, got.status);
                    if (o_payload_addr !== got.payload_addr)
                        report_mismatch("payload_addr", o_payload_addr, got.payload_addr);
                    if (o_byte_count !== got.byte_count)
                        report_mismatch("byte_count", o_byte_count, got.byte_count);
                end
            end
            if (start && !busy) begin
                r = serve_request(t_req'(i_req_type), i_req_size, i_block_addr);
                if (t_req'(i_req_type) == REQ_ALLOC && r.status == ST_OK)
                    live_blocks.push_back(r.payload_addr);
                if (t_req'(i_req_type) == REQ_FREE && r.status == ST_OK) begin
                    idx = -1;
                    foreach (live_blocks[k]) if (live_blocks[k] == i_block_addr) idx = k;
                    if (idx >= 0) live_blocks.delete(idx);
                end
                if (typed_rows.size() > 0) begin
                    row = typed_rows.pop_front();
                    r = row.reply;
                end
                pending_replies.push_back(r);
            end
        end
    end

    task automatic send_item(t_req req, int size, int addr);
        start <= 1'b1;
        i_req_type <= req;
        i_req_size <= 13'(size);
        i_block_addr <= 12'(addr);
        do @(posedge i_clk); while (busy);
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_pool_size(int value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 13'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        format_pool(value);
        live_blocks.delete();
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic random_item;
        int pick;
        int size;
        int addr;
        t_req req;
        pick = $urandom_range(99);
        size = $urandom_range(0, 96);
        addr = $urandom_range(0, 4095);
        if (pick < 45) begin
            req = REQ_ALLOC;
            if ($urandom_range(9) == 0) size = $urandom_range(0, 8191);
        end else if (pick < 85) begin
            req = REQ_FREE;
            if (live_blocks.size() > 0 && $urandom_range(9) != 0)
                addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        end else begin
            req = t_req'($urandom_range(2, 3));
        end
        send_item(req, size, addr);
    endtask

    task automatic add_row(t_req req, int size, int addr, bit typed,
                           t_status st = ST_OK, int paddr = 0, int cnt = 0);
        t_row row;
        row.req = req;
        row.size = size;
        row.addr = addr;
        row.typed = typed;
        row.reply.status = st;
        row.reply.payload_addr = 12'(paddr);
        row.reply.byte_count = 13'(cnt);
        typed_rows.push_back(row);
    endtask

    initial begin
        t_row table_rows[$];
        int phase_pct[4];
        int settings[5];
        phase_pct = '{0, 68, 0, 8};
        settings = '{32, 8191, 0, 100, 4096};
        mismatches = 0;
        items_sent = 0;
        replies_seen = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = '0;
        i_req_size = '0;
        i_block_addr = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        format_pool(4096);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        add_row(REQ_SUM,     0,    0,    1, ST_OK, 0, 4080);
        add_row(REQ_LARGEST, 0,    0,    1, ST_OK, 0, 4080);
        add_row(REQ_ALLOC,   0,    0,    1, ST_NOSPACE);
        add_row(REQ_ALLOC,   8191, 0,    1, ST_NOSPACE);
        add_row(REQ_FREE,    0,    4095, 1, ST_NOTALLOC);
        add_row(REQ_ALLOC,   1,    0,    1, ST_OK, 8);
        add_row(REQ_FREE,    0,    8,    1, ST_OK);
        add_row(REQ_FREE,    0,    8,    1, ST_NOTALLOC);
        add_row(REQ_ALLOC,   4080, 0,    1, ST_OK, 8);
        add_row(REQ_SUM,     0,    0,    1, ST_OK, 0, 0);
        add_row(REQ_LARGEST, 0,    0,    1, ST_OK, 0, 0);
        add_row(REQ_ALLOC,   8,    0,    1, ST_NOSPACE);
        add_row(REQ_FREE,    0,    8,    1, ST_OK);
        add_row(REQ_ALLOC,   4072, 0,    1, ST_OK, 8);
        add_row(REQ_SUM,     0,    0,    1, ST_OK, 0, 0);
        add_row(REQ_FREE,    0,    8,    1, ST_OK);
        add_row(REQ_ALLOC,   4064, 0,    1, ST_OK, 8);
        add_row(REQ_SUM,     0,    0,    1, ST_OK, 0, 8);
        add_row(REQ_FREE,    0,    0,    1, ST_NOTALLOC);
        add_row(REQ_FREE,    0,    8,    1, ST_OK);
        add_row(REQ_ALLOC,   4096, 0,    1, ST_NOSPACE);
        add_row(REQ_ALLOC,   24,   0,    0);
        add_row(REQ_ALLOC,   40,   0,    0);
        add_row(REQ_FREE,    0,    8,    0);
        add_row(REQ_LARGEST, 0,    0,    0);

        // Untyped rows are checked against the predictor alone.
        table_rows = typed_rows;
        typed_rows.delete();
        foreach (table_rows[k]) if (table_rows[k].typed) typed_rows.push_back(table_rows[k]);
        foreach (table_rows[k]) begin
            if (!table_rows[k].typed) begin
                while (typed_rows.size() != 0) @(posedge i_clk);
            end
            send_item(table_rows[k].req, table_rows[k].size, table_rows[k].addr);
        end

        for (int p = 0; p < 5; p++) begin
            write_pool_size(settings[p]);
            idle_pct = phase_pct[p % 4];
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) random_item();
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d items over five pool sizes, %0d results compared, %0d mismatches.",
                 items_sent, replies_seen, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
